FILE: rtl/core/ispp_pkg.sv
// ispp_pkg: constants, command and status types for the slotted page packer
// no dependencies; imported by every module of the block

package ispp_pkg;

  localparam int unsigned PAGE_BYTES   = 1024;
  localparam int unsigned HEADER_BYTES = 12;
  localparam int unsigned DATA_BYTES   = PAGE_BYTES - HEADER_BYTES;
  localparam int unsigned ROWS         = PAGE_BYTES / 16;
  localparam int unsigned MAX_STR      = 255;
  localparam int unsigned STRING_LIMIT = (MAX_STR < PAGE_BYTES - 16) ? MAX_STR : PAGE_BYTES - 16;

  localparam int unsigned PA_W  = $clog2(PAGE_BYTES);
  localparam int unsigned ROW_W = $clog2(ROWS);
  localparam int unsigned LEN_W = 8;
  localparam int unsigned CNT_W = 8;

  localparam logic [0:0] OP_BYTE  = 1'b0;
  localparam logic [0:0] OP_FLUSH = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_RD,
    S_LD,
    S_WAIT,
    S_STORE,
    S_SLOT,
    S_COPY
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic take_byte;
    logic commit;
    logic slot_wr;
    logic str_step;
    logic row_rd;
    logic load_out;
    logic row_next;
    logic new_page;
    logic clr_len;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic free_short;
    logic page_nz;
    logic slot_last;
    logic str_done;
    logic row_last;
  } sts_t;

  // header byte at page position pos (0..11)
  function automatic logic [7:0] hdr_byte(input logic [3:0] pos, input logic [31:0] first,
                                          input logic [CNT_W-1:0] count);
    logic [31:0] dsz;
    logic [7:0]  b;
    dsz = 32'(DATA_BYTES);
    case (pos)
      4'd0:    b = first[31:24];
      4'd1:    b = first[23:16];
      4'd2:    b = first[15:8];
      4'd3:    b = first[7:0];
      4'd7:    b = count;
      4'd8:    b = dsz[31:24];
      4'd9:    b = dsz[23:16];
      4'd10:   b = dsz[15:8];
      4'd11:   b = dsz[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

FILE: rtl/core/ispp_if.sv
// ispp_in_if and ispp_out_if: valid/ready channels of the packer
// depends on nothing

interface ispp_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] id_byte;
  logic       id_end;
  modport source (output valid, opcode, id_byte, id_end, input ready);
  modport sink   (input valid, opcode, id_byte, id_end, output ready);
endinterface

interface ispp_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] word_high;
  logic [63:0] word_low;
  logic [5:0]  word_number;
  logic        page_done;
  modport source (output valid, word_high, word_low, word_number, page_done, input ready);
  modport sink   (input valid, word_high, word_low, word_number, page_done, output ready);
endinterface

FILE: rtl/core/ispp_ctrl.sv
// ispp_ctrl: sequencing state machine of the packer
// depends on ispp_pkg

module ispp_ctrl
  import ispp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_opcode_i,
  input  logic in_end_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   flush_q, flush_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      flush_q <= 1'b0;
    end else begin
      state_q <= state_d;
      flush_q <= flush_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    flush_d     = flush_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_opcode_i == OP_FLUSH) begin
            if (sts_i.page_nz) begin
              flush_d = 1'b1;
              state_d = S_RD;
            end
          end else begin
            cmd_o.take_byte = 1'b1;
            if (in_end_i) state_d = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        flush_d = 1'b0;
        state_d = sts_i.free_short ? S_RD : S_STORE;
      end
      S_RD: begin
        cmd_o.row_rd = 1'b1;
        state_d = S_LD;
      end
      S_LD: begin
        cmd_o.load_out = 1'b1;
        state_d = S_WAIT;
      end
      S_WAIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.row_next = 1'b1;
          if (sts_i.row_last) begin
            cmd_o.new_page = 1'b1;
            state_d = flush_q ? S_IDLE : S_STORE;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_STORE: begin
        cmd_o.commit = 1'b1;
        state_d = S_SLOT;
      end
      S_SLOT: begin
        cmd_o.slot_wr = 1'b1;
        if (sts_i.slot_last) state_d = S_COPY;
      end
      S_COPY: begin
        cmd_o.str_step = 1'b1;
        if (sts_i.str_done) begin
          cmd_o.clr_len = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

FILE: rtl/core/ispp_dp.sv
// ispp_dp: string buffer, page memory, page header registers and output word
// depends on ispp_pkg

module ispp_dp
  import ispp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic [7:0]  id_byte_i,
  output logic [63:0] word_high_o,
  output logic [63:0] word_low_o,
  output logic [5:0]  word_number_o,
  output logic        page_done_o
);

  logic [7:0] sbuf [STRING_LIMIT];
  logic [7:0] page_mem [ROWS][16];

  logic [LEN_W-1:0] len_q;
  logic [31:0]      first_q;
  logic [CNT_W-1:0] count_q;
  logic [PA_W-1:0]  low_q;
  logic [PA_W-1:0]  spt_q;
  logic [1:0]       j_q;
  logic [LEN_W-1:0] c_q;
  logic [PA_W-1:0]  wp_q;
  logic [ROW_W-1:0] row_q;
  logic [7:0]       sb_rd_q;
  logic [7:0]       row_rd_q [16];

  logic [PA_W-1:0]  slot_end;
  logic [PA_W-1:0]  free_b;
  logic [PA_W-1:0]  low_new;
  logic [7:0]       slot_byte;
  logic             wr_en;
  logic [PA_W-1:0]  wr_addr;
  logic [7:0]       wr_data;
  logic [7:0]       lane_b [16];

  assign slot_end = {count_q, 2'b00};
  assign free_b   = low_q - slot_end;
  assign low_new  = low_q - PA_W'(len_q);

  // status
  assign sts_o.free_short = free_b < (PA_W'(len_q) + PA_W'(4));
  assign sts_o.page_nz    = count_q != '0;
  assign sts_o.slot_last  = j_q == 2'd3;
  assign sts_o.str_done   = c_q == len_q;
  assign sts_o.row_last   = row_q == ROW_W'(ROWS - 1);

  // big-endian slot bytes of the new data offset
  always_comb begin
    case (j_q)
      2'd2:    slot_byte = 8'(low_q >> 8);
      2'd3:    slot_byte = low_q[7:0];
      default: slot_byte = 8'h00;
    endcase
  end

  // single page write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = wp_q;
    wr_data = sb_rd_q;
    if (cmd_i.slot_wr) begin
      wr_en   = 1'b1;
      wr_addr = spt_q + PA_W'(j_q);
      wr_data = slot_byte;
    end else if (cmd_i.str_step && c_q != '0) begin
      wr_en = 1'b1;
    end
  end

  // string buffer
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_byte && len_q < LEN_W'(STRING_LIMIT)) sbuf[len_q] <= id_byte_i;
    if (cmd_i.str_step && c_q < len_q) sb_rd_q <= sbuf[c_q];
  end

  // page memory, byte write, row read
  always_ff @(posedge clk_i) begin
    if (wr_en) page_mem[wr_addr[PA_W-1:4]][wr_addr[3:0]] <= wr_data;
    if (cmd_i.row_rd) begin
      for (int l = 0; l < 16; l++) row_rd_q[l] <= page_mem[row_q][l];
    end
  end

  // page state and copy counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      first_q <= '0;
      count_q <= '0;
      low_q   <= PA_W'(DATA_BYTES);
      spt_q   <= '0;
      j_q     <= '0;
      c_q     <= '0;
      wp_q    <= '0;
      row_q   <= '0;
    end else begin
      if (cmd_i.take_byte && len_q < LEN_W'(STRING_LIMIT)) len_q <= len_q + LEN_W'(1);
      if (cmd_i.clr_len) len_q <= '0;
      if (cmd_i.new_page) begin
        first_q <= first_q + 32'(count_q);
        count_q <= '0;
        low_q   <= PA_W'(DATA_BYTES);
      end
      if (cmd_i.commit) begin
        low_q   <= low_new;
        count_q <= count_q + CNT_W'(1);
        spt_q   <= PA_W'(HEADER_BYTES) + slot_end;
        wp_q    <= PA_W'(HEADER_BYTES) + low_new;
        j_q     <= '0;
        c_q     <= '0;
      end
      if (cmd_i.slot_wr) j_q <= j_q + 2'd1;
      if (cmd_i.str_step) begin
        c_q <= c_q + LEN_W'(1);
        if (c_q != '0) wp_q <= wp_q + PA_W'(1);
      end
      if (cmd_i.row_next) row_q <= row_q + ROW_W'(1);
    end
  end

  // header insertion and gap zeroing per lane
  always_comb begin
    for (int l = 0; l < 16; l++) begin
      logic [PA_W-1:0] p;
      logic [PA_W-1:0] d;
      p = {row_q, 4'(l)};
      d = p - PA_W'(HEADER_BYTES);
      if (p < PA_W'(HEADER_BYTES)) lane_b[l] = hdr_byte(p[3:0], first_q, count_q);
      else if (d >= slot_end && d < low_q) lane_b[l] = 8'h00;
      else lane_b[l] = row_rd_q[l];
    end
  end

  // output word register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      for (int l = 0; l < 8; l++) begin
        word_high_o[63-8*l -: 8] <= lane_b[l];
        word_low_o[63-8*l -: 8]  <= lane_b[l+8];
      end
      word_number_o <= 6'(row_q);
      page_done_o   <= row_q == ROW_W'(ROWS - 1);
    end
  end

endmodule

FILE: rtl/core/id_slotted_page_packer_top.sv
// id_slotted_page_packer_top: identifier packer into slotted pages
// depends on ispp_pkg, ispp_if, ispp_ctrl, ispp_dp
//
//   channel | dir | payload                                   | transaction
//   in_i    | in  | opcode, id_byte, id_end                   | one byte or flush
//   out_o   | out | word_high, word_low, word_number, page_done | one 16-byte page word
//
// a byte that does not end a string is taken in idle with nothing further; an
// ending byte adds a check state, a commit, a four-byte slot write, and a copy
// of each string byte through the single page write port after a priming buffer read.
// a page is emitted as 64 words, each by row read, load and handshake.
// output stalls hold the block in emission; no input is taken meanwhile.
// reset clears the page header state; memory contents are never cleared.

module id_slotted_page_packer_top
  import ispp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  ispp_in_if.sink    in_i,
  ispp_out_if.source out_o
);

  cmd_t cmd;
  sts_t sts;

  ispp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_opcode_i(in_i.opcode),
    .in_end_i   (in_i.id_end),
    .in_ready_o (in_i.ready),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ispp_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .id_byte_i    (in_i.id_byte),
    .word_high_o  (out_o.word_high),
    .word_low_o   (out_o.word_low),
    .word_number_o(out_o.word_number),
    .page_done_o  (out_o.page_done)
  );

endmodule
